FILE: rtl/improved_gradient_noise_3d_defines.svh
// Assertion macros shared by the improved gradient noise 3D RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef IMPROVED_GRADIENT_NOISE_3D_DEFINES_SVH
`define IMPROVED_GRADIENT_NOISE_3D_DEFINES_SVH

// Consequent is checked in the same cycle as the antecedent.
`define IGN_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent is checked in the cycle after the antecedent.
`define IGN_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ign_pkg.sv
// Package for the improved gradient noise 3D block: widths, codes, types
// and the gradient function. No dependencies.
`default_nettype none

package ign_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int CELL_BITS  = 8;
   localparam int TABLE_SIZE = 256;
   localparam int FADE_W     = 18;
   localparam int COORD_W    = 18;
   localparam int GRAD_W     = 19;
   localparam int VAL_W      = 24;
   localparam int OUT_W      = 18;
   localparam int OFFSET_W   = 24;

   localparam logic [3:0] HASH_MASK = 4'hF;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;

   typedef enum logic {
      OP_EVAL  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // Write port of one permutation table copy.
   typedef struct packed {
      logic                 en;
      logic [CELL_BITS-1:0] addr;
      logic [CELL_BITS-1:0] data;
   } perm_wr_type;

   // Dot product of a cube-edge direction, chosen by the hash, with the corner offset.
   function automatic logic signed [GRAD_W-1:0] grad_dot(
      input logic [CELL_BITS-1:0]      hash,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z
   );
      logic [3:0]               h;
      logic signed [GRAD_W-1:0] gu;
      logic signed [GRAD_W-1:0] gv;
      h  = hash[3:0] & HASH_MASK;
      gu = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
      if (h < 4'd4) begin
         gv = GRAD_W'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         gv = GRAD_W'(x);
      end else begin
         gv = GRAD_W'(z);
      end
      if (h[0]) begin
         gu = -gu;
      end
      if (h[1]) begin
         gv = -gv;
      end
      return gu + gv;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ign_perm_ram.sv
// One copy of the 256-entry permutation table with two read ports.
// Depends on ign_pkg. Entries never written read back as their own index.
`default_nettype none

module ign_perm_ram (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ign_pkg::perm_wr_type          wr,
   input  wire logic [ign_pkg::CELL_BITS-1:0] rd_addr_a,
   input  wire logic [ign_pkg::CELL_BITS-1:0] rd_addr_b,
   output logic      [ign_pkg::CELL_BITS-1:0] rd_data_a,
   output logic      [ign_pkg::CELL_BITS-1:0] rd_data_b
);

   logic [ign_pkg::CELL_BITS-1:0] mem_ff [ign_pkg::TABLE_SIZE];
   logic [ign_pkg::TABLE_SIZE-1:0] written_ff;
   logic [ign_pkg::CELL_BITS-1:0] data_a_ff, data_b_ff, addr_a_ff, addr_b_ff;
   logic                          hit_a_ff, hit_b_ff;

   // Storage array and registered reads.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      data_a_ff <= mem_ff[rd_addr_a];
      data_b_ff <= mem_ff[rd_addr_b];
      addr_a_ff <= rd_addr_a;
      addr_b_ff <= rd_addr_b;
   end

   // Written flags; reset returns the table to identity at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         hit_a_ff   <= 1'b0;
         hit_b_ff   <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         hit_a_ff <= written_ff[rd_addr_a];
         hit_b_ff <= written_ff[rd_addr_b];
      end
   end

   assign rd_data_a = hit_a_ff ? data_a_ff : addr_a_ff;
   assign rd_data_b = hit_b_ff ? data_b_ff : addr_b_ff;

endmodule

`default_nettype wire

FILE: rtl/ign_fade.sv
// Four-stage fade curve 6t^5-15t^4+10t^3 in fixed point.
// Depends on ign_pkg.
`default_nettype none

module ign_fade (
   input  wire logic                          clock,
   input  wire logic [ign_pkg::FRAC_BITS-1:0] t,
   output logic      [ign_pkg::FADE_W-1:0]    fade
);

   localparam logic [39:0] HALF = 40'd1 << (ign_pkg::FRAC_BITS - 1);

   logic [15:0] t_s1_ff, t_s2_ff;
   logic [31:0] tt_ff;
   logic [16:0] t2_ff;
   logic [20:0] pf_ff, pf_s3_ff;
   logic [17:0] t3_ff;
   logic [17:0] fade_ff;

   logic [36:0] poly;
   logic [36:0] poly_r;
   logic [31:0] tt_r;
   logic [33:0] t3_r;
   logic [39:0] fade_r;

   // Square of the fraction, t^2 rounding, polynomial and t^3, final product.
   always_comb begin
      tt_r   = tt_ff + HALF[31:0];
      poly   = 37'(tt_ff) * 37'd6 + (37'd10 << 32) - ((37'(t_s1_ff) * 37'd15) << 16);
      poly_r = poly + HALF[36:0];
      t3_r   = 34'(t2_ff) * 34'(t_s2_ff) + HALF[33:0];
      fade_r = 40'(t3_ff) * 40'(pf_s3_ff) + HALF;
   end

   always_ff @(posedge clock) begin
      t_s1_ff  <= t;
      tt_ff    <= 32'(t) * 32'(t);
      t_s2_ff  <= t_s1_ff;
      t2_ff    <= {tt_r < tt_ff, tt_r[31:16]};
      pf_ff    <= poly_r[36:16];
      t3_ff    <= t3_r[33:16];
      pf_s3_ff <= pf_ff;
      fade_ff  <= fade_r[33:16];
   end

   assign fade = fade_ff;

endmodule

`default_nettype wire

FILE: rtl/ign_lerp.sv
// Two-stage linear blend a + round((b - a) * w) with half-up rounding.
// Depends on ign_pkg.
`default_nettype none

module ign_lerp (
   input  wire logic                             clock,
   input  wire logic signed [ign_pkg::VAL_W-1:0] a,
   input  wire logic signed [ign_pkg::VAL_W-1:0] b,
   input  wire logic        [ign_pkg::FADE_W-1:0] w,
   output logic      signed [ign_pkg::VAL_W-1:0] y
);

   localparam int PW = 44;
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (ign_pkg::FRAC_BITS - 1);

   logic signed [ign_pkg::VAL_W-1:0] a_ff, y_ff;
   logic signed [PW-1:0]             prod_ff;
   logic signed [ign_pkg::VAL_W:0]   diff;
   logic signed [ign_pkg::FADE_W:0]  ws;
   logic signed [PW-1:0]             rounded;

   // Multiply the difference by the weight, then round and add back.
   always_comb begin
      diff    = (ign_pkg::VAL_W+1)'(b) - (ign_pkg::VAL_W+1)'(a);
      ws      = signed'({1'b0, w});
      rounded = (prod_ff + HALF) >>> ign_pkg::FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      a_ff    <= a;
      prod_ff <= PW'(diff) * PW'(ws);
      y_ff    <= a_ff + rounded[ign_pkg::VAL_W-1:0];
   end

   assign y = y_ff;

endmodule

`default_nettype wire

FILE: rtl/improved_gradient_noise_3d.sv
// Improved gradient noise 3D: takes one point per clock and returns its noise value
// for a single cycle under rsp_strobe. busy is raised only while reset is held, so a
// command may be issued every cycle, and the receiver must take each result when it
// appears since it cannot stall the pipeline. The latency is set by the chain of three
// dependent permutation lookups followed by three rounds of multiply-and-round
// blending. A write command updates the table and gives no result; points issued
// after it see the new entry, points before it do not. The user must write offsets
// over the APB port only while no command is in flight; the block does not enforce
// this. Depends on ign_pkg, ign_perm_ram, ign_fade, ign_lerp and the defines header.
`default_nettype none
`include "improved_gradient_noise_3d_defines.svh"

module improved_gradient_noise_3d (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Command channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_op,
   input  wire logic signed [31:0]               req_pos_x,
   input  wire logic signed [31:0]               req_pos_y,
   input  wire logic signed [31:0]               req_pos_z,
   input  wire logic [7:0]                       req_entry_index,
   input  wire logic [7:0]                       req_entry_value,
   // Result channel
   output logic                                  rsp_strobe,
   output logic signed [ign_pkg::OUT_W-1:0]      rsp_noise_value,
   // Configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [3:0]                       paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int CB = ign_pkg::CELL_BITS;
   localparam int FB = ign_pkg::FRAC_BITS;
   localparam int VW = ign_pkg::VAL_W;
   localparam int OW = ign_pkg::OFFSET_W;
   localparam logic signed [VW-1:0] SAT_MAX = VW'((1 <<< (ign_pkg::OUT_W - 1)) - 1);
   localparam logic signed [VW-1:0] SAT_MIN = -VW'(1 <<< (ign_pkg::OUT_W - 1));
   localparam logic signed [ign_pkg::COORD_W-1:0] ONE = ign_pkg::COORD_W'(1 << FB);

   logic accept;
   logic cfg_wr;

   // Configuration registers
   logic [OW-1:0] off_x_ff, off_y_ff, off_z_ff;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            ign_pkg::REG_OFFSET_X: off_x_ff <= pwdata[OW-1:0];
            ign_pkg::REG_OFFSET_Y: off_y_ff <= pwdata[OW-1:0];
            ign_pkg::REG_OFFSET_Z: off_z_ff <= pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         ign_pkg::REG_OFFSET_X: prdata = 32'(off_x_ff);
         ign_pkg::REG_OFFSET_Y: prdata = 32'(off_y_ff);
         ign_pkg::REG_OFFSET_Z: prdata = 32'(off_z_ff);
         default:               prdata = '0;
      endcase
   end

   // Command acceptance; the pipeline never stalls, commands wait only for reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Stage 1: offset add, cell and fraction split.
   logic [3:1]    vld_ff;
   logic [3:1]    wop_ff;
   logic [CB-1:0] wi_ff [3:1];
   logic [CB-1:0] wv_ff [3:1];
   logic [CB-1:0] cx1_ff, cy1_ff, cz1_ff, cy2_ff, cz2_ff, cz3_ff;
   logic [FB-1:0] fx_ff [4:1];
   logic [FB-1:0] fy_ff [4:1];
   logic [FB-1:0] fz_ff [4:1];
   logic [OW-1:0] sx, sy, sz;

   assign sx = req_pos_x[OW-1:0] + off_x_ff;
   assign sy = req_pos_y[OW-1:0] + off_y_ff;
   assign sz = req_pos_z[OW-1:0] + off_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      wop_ff   <= {wop_ff[2:1], (req_op == ign_pkg::OP_WRITE)};
      wi_ff[1] <= req_entry_index;
      wv_ff[1] <= req_entry_value;
      wi_ff[2] <= wi_ff[1];
      wv_ff[2] <= wv_ff[1];
      wi_ff[3] <= wi_ff[2];
      wv_ff[3] <= wv_ff[2];
      cx1_ff   <= sx[OW-1:FB];
      cy1_ff   <= sy[OW-1:FB];
      cz1_ff   <= sz[OW-1:FB];
      cy2_ff   <= cy1_ff;
      cz2_ff   <= cz1_ff;
      cz3_ff   <= cz2_ff;
      fx_ff[1] <= sx[FB-1:0];
      fy_ff[1] <= sy[FB-1:0];
      fz_ff[1] <= sz[FB-1:0];
      for (int i = 2; i <= 4; i++) begin
         fx_ff[i] <= fx_ff[i-1];
         fy_ff[i] <= fy_ff[i-1];
         fz_ff[i] <= fz_ff[i-1];
      end
   end

   // Table writes land in each copy as the write beat passes its stage.
   ign_pkg::perm_wr_type wr_g0, wr_g1, wr_g2;

   always_comb begin
      wr_g0 = '{en: vld_ff[1] && wop_ff[1], addr: wi_ff[1], data: wv_ff[1]};
      wr_g1 = '{en: vld_ff[2] && wop_ff[2], addr: wi_ff[2], data: wv_ff[2]};
      wr_g2 = '{en: vld_ff[3] && wop_ff[3], addr: wi_ff[3], data: wv_ff[3]};
   end

   // First lookup: P[cx] and P[cx+1].
   logic [CB-1:0] p_a, p_b;

   ign_perm_ram u_ram_g0 (
      .clock(clock), .reset(reset), .wr(wr_g0),
      .rd_addr_a(cx1_ff), .rd_addr_b(cx1_ff + 8'd1),
      .rd_data_a(p_a), .rd_data_b(p_b)
   );

   // Second lookup: rows a and b.
   logic [CB-1:0] ha, hb, p_aa0, p_aa1, p_bb0, p_bb1;

   assign ha = p_a + cy2_ff;
   assign hb = p_b + cy2_ff;

   ign_perm_ram u_ram_g1a (
      .clock(clock), .reset(reset), .wr(wr_g1),
      .rd_addr_a(ha), .rd_addr_b(ha + 8'd1),
      .rd_data_a(p_aa0), .rd_data_b(p_aa1)
   );

   ign_perm_ram u_ram_g1b (
      .clock(clock), .reset(reset), .wr(wr_g1),
      .rd_addr_a(hb), .rd_addr_b(hb + 8'd1),
      .rd_data_a(p_bb0), .rd_data_b(p_bb1)
   );

   // Third lookup: the eight corner hashes.
   logic [CB-1:0] h_aa, h_ab, h_ba, h_bb;
   logic [CB-1:0] g_aa0, g_aa1, g_ab0, g_ab1, g_ba0, g_ba1, g_bb0, g_bb1;

   assign h_aa = p_aa0 + cz3_ff;
   assign h_ab = p_aa1 + cz3_ff;
   assign h_ba = p_bb0 + cz3_ff;
   assign h_bb = p_bb1 + cz3_ff;

   ign_perm_ram u_ram_g2a (
      .clock(clock), .reset(reset), .wr(wr_g2),
      .rd_addr_a(h_aa), .rd_addr_b(h_aa + 8'd1),
      .rd_data_a(g_aa0), .rd_data_b(g_aa1)
   );

   ign_perm_ram u_ram_g2b (
      .clock(clock), .reset(reset), .wr(wr_g2),
      .rd_addr_a(h_ba), .rd_addr_b(h_ba + 8'd1),
      .rd_data_a(g_ba0), .rd_data_b(g_ba1)
   );

   ign_perm_ram u_ram_g2c (
      .clock(clock), .reset(reset), .wr(wr_g2),
      .rd_addr_a(h_ab), .rd_addr_b(h_ab + 8'd1),
      .rd_data_a(g_ab0), .rd_data_b(g_ab1)
   );

   ign_perm_ram u_ram_g2d (
      .clock(clock), .reset(reset), .wr(wr_g2),
      .rd_addr_a(h_bb), .rd_addr_b(h_bb + 8'd1),
      .rd_data_a(g_bb0), .rd_data_b(g_bb1)
   );

   // Fade weights, ready at stage 5.
   logic [ign_pkg::FADE_W-1:0] fade_u, fade_v, fade_w;

   ign_fade u_fade_x (.clock(clock), .t(fx_ff[1]), .fade(fade_u));
   ign_fade u_fade_y (.clock(clock), .t(fy_ff[1]), .fade(fade_v));
   ign_fade u_fade_z (.clock(clock), .t(fz_ff[1]), .fade(fade_w));

   // Stage 5: gradient dot products at the eight corners.
   logic signed [ign_pkg::COORD_W-1:0] x0, y0, z0, x1, y1, z1;
   logic signed [VW-1:0]               grad_ff [8];

   always_comb begin
      x0 = signed'({2'b00, fx_ff[4]});
      y0 = signed'({2'b00, fy_ff[4]});
      z0 = signed'({2'b00, fz_ff[4]});
      x1 = x0 - ONE;
      y1 = y0 - ONE;
      z1 = z0 - ONE;
   end

   always_ff @(posedge clock) begin
      grad_ff[0] <= VW'(ign_pkg::grad_dot(g_aa0, x0, y0, z0));
      grad_ff[1] <= VW'(ign_pkg::grad_dot(g_ba0, x1, y0, z0));
      grad_ff[2] <= VW'(ign_pkg::grad_dot(g_ab0, x0, y1, z0));
      grad_ff[3] <= VW'(ign_pkg::grad_dot(g_bb0, x1, y1, z0));
      grad_ff[4] <= VW'(ign_pkg::grad_dot(g_aa1, x0, y0, z1));
      grad_ff[5] <= VW'(ign_pkg::grad_dot(g_ba1, x1, y0, z1));
      grad_ff[6] <= VW'(ign_pkg::grad_dot(g_ab1, x0, y1, z1));
      grad_ff[7] <= VW'(ign_pkg::grad_dot(g_bb1, x1, y1, z1));
   end

   // Weight delay lines to meet the y and z blend levels.
   logic [ign_pkg::FADE_W-1:0] v_ff [7:6];
   logic [ign_pkg::FADE_W-1:0] w_ff [9:6];

   always_ff @(posedge clock) begin
      v_ff[6] <= fade_v;
      v_ff[7] <= v_ff[6];
      w_ff[6] <= fade_w;
      for (int i = 7; i <= 9; i++) begin
         w_ff[i] <= w_ff[i-1];
      end
   end

   // Trilinear blend: x level, y level, z level.
   logic signed [VW-1:0] lx [4];
   logic signed [VW-1:0] ly [2];
   logic signed [VW-1:0] lz;

   for (genvar i = 0; i < 4; i++) begin : g_lerp_x
      ign_lerp u_lerp (
         .clock(clock), .a(grad_ff[2*i]), .b(grad_ff[2*i+1]), .w(fade_u), .y(lx[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_lerp_y
      ign_lerp u_lerp (
         .clock(clock), .a(lx[2*i]), .b(lx[2*i+1]), .w(v_ff[7]), .y(ly[i])
      );
   end

   ign_lerp u_lerp_z (.clock(clock), .a(ly[0]), .b(ly[1]), .w(w_ff[9]), .y(lz));

   // Evaluate-beat valid bits for stages 4 to 11, then the result register.
   logic [11:4]                ev_ff;
   logic                       strobe_ff;
   logic signed [ign_pkg::OUT_W-1:0] noise_ff;
   logic signed [VW-1:0]       sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ev_ff     <= {ev_ff[10:4], vld_ff[3] && !wop_ff[3]};
         strobe_ff <= ev_ff[11];
      end
   end

   // Saturate the blended value to the output range.
   always_comb begin
      if (lz > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (lz < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = lz;
      end
   end

   always_ff @(posedge clock) begin
      noise_ff <= sat[ign_pkg::OUT_W-1:0];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_noise_value = noise_ff;

   // Checks on latency and on the write beat's travel from the first to the second lookup stage.
   `IGN_ASSERT_SAME(a_eval_gives_result, accept && (req_op == ign_pkg::OP_EVAL), ##12 rsp_strobe, "evaluate beat did not produce a result after 12 cycles")
   `IGN_ASSERT_SAME(a_write_no_result, accept && (req_op == ign_pkg::OP_WRITE), ##12 !rsp_strobe, "write beat produced a result")
   `IGN_ASSERT_NEXT(a_write_travels, wr_g0.en, wr_g1.en && (wr_g1.addr == $past(wr_g0.addr)), "table write lost between lookup stages")

endmodule

`default_nettype wire
